// ===== rtl/core/bmf_pkg.sv =====
`default_nettype none

package bmf_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int PIX_W       = 8;
  localparam int SIZE_W      = 6;
  localparam int CNT_W       = $clog2(MAX_SIDE);
  localparam int SUM_W       = PIX_W + 4;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam int RESET_SIDE  = (MAX_SIDE < 8) ? MAX_SIDE : 8;

  // Reciprocals scaled by 2**RECIP_SHIFT; exact truncation for every reachable sum.
  localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
  localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } pair_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col3_t;

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_t;

  typedef enum logic [1:0] {
    FL_IDLE,
    FL_EDGE,
    FL_ROW
  } fl_state_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    div_t             div;
    logic             last;
    logic             eof;
  } win_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmf_line_cell.sv =====
`default_nettype none

module bmf_line_cell import bmf_pkg::*; (
  input  logic  clk,
  input  logic  shift_en,
  input  logic  is_tail,
  input  pair_t new_pair,
  input  pair_t next_pair,
  output pair_t pair
);

  pair_t pair_r;
  pair_t pair_nxt;

  // The tail cell takes the newest column, every other cell takes its neighbor's.
  always_comb begin
    pair_nxt = pair_r;
    if (shift_en) begin
      pair_nxt = is_tail ? new_pair : next_pair;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
  end

  assign pair = pair_r;

endmodule

`default_nettype wire

// ===== rtl/core/bmf_mean_pipe.sv =====
`default_nettype none

module bmf_mean_pipe import bmf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       a_load,
  input  win_res_t   a_data,
  output logic       a_ready,
  input  logic       out_stall,
  output logic       out_valid,
  output pix_t       out_pixel,
  output logic       out_last,
  output logic       out_eof
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic                 a_valid_r, a_valid_nxt;
  win_res_t             a_r, a_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pix_t                 pix_r, pix_nxt;
  logic                 last_r, last_nxt;
  logic                 eof_r, eof_nxt;
  logic                 b_adv;
  logic [RECIP_W-1:0]   recip;
  logic [PROD_W-1:0]    product;

  assign b_adv   = !out_valid_r || !out_stall;
  assign a_ready = !a_valid_r || b_adv;

  always_comb begin
    case (a_r.div)
      DIV4:    recip = RECIP_4;
      DIV6:    recip = RECIP_6;
      DIV9:    recip = RECIP_9;
      default: recip = RECIP_4;
    endcase
  end

  assign product = PROD_W'(a_r.sum) * PROD_W'(recip);

  always_comb begin
    a_valid_nxt   = a_valid_r;
    a_nxt         = a_r;
    out_valid_nxt = out_valid_r;
    pix_nxt       = pix_r;
    last_nxt      = last_r;
    eof_nxt       = eof_r;
    if (b_adv) begin
      out_valid_nxt = a_valid_r;
      pix_nxt       = product[RECIP_SHIFT +: PIX_W];
      last_nxt      = a_r.last;
      eof_nxt       = a_r.eof;
    end
    if (a_ready) begin
      a_valid_nxt = a_load;
      if (a_load) begin
        a_nxt = a_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r    <= a_nxt;
    pix_r  <= pix_nxt;
    last_r <= last_nxt;
    eof_r  <= eof_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = pix_r;
  assign out_last  = last_r;
  assign out_eof   = eof_r;

endmodule

`default_nettype wire

// ===== rtl/core/box_mean_filter_3x3_core.sv =====
`default_nettype none

// 3x3 box mean filter for a square image of S x S 8-bit pixels (S from the image_size
// register, 2..MAX_SIDE, reset 8) streamed in raster order. Each result is the truncated
// mean of the in-bounds 3x3 neighborhood of the original pixels. The block takes one pixel
// per cycle while in_stall is low; results trail the input by one row plus one pixel, and
// each passes through a two-stage result path (window sum, then reciprocal multiply) before
// it appears on the output register. The last pixel of a frame starts a flush of S+1
// further results (the last pixel of the next-to-last row and the whole final row), one per
// cycle while the output is not stalled, during which the input is stalled. The two line
// stores are a chain of S cells that shifts once per pixel and recirculates during the
// flush. Writing image_size restarts the frame.
module box_mean_filter_3x3_core import bmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_pixel_out,
  output logic              out_last_in_run,
  output logic              out_end_of_frame
);

  logic [CNT_W-1:0]  last_idx_r, last_idx_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  fl_k_r, fl_k_nxt;
  fl_state_t         fl_state_r, fl_state_nxt;
  col3_t             wnew_r, wnew_nxt;
  col3_t             wold_r, wold_nxt;
  pair_t             fw_left_r, fw_left_nxt;
  pair_t             fw_mid_r, fw_mid_nxt;

  logic [SIZE_W-1:0] size_clamp;
  logic [SIZE_W-1:0] size_m1;
  logic              accept;
  logic              last_pix;
  logic              acc_emits;
  logic              fl_busy;
  logic              fl_go;
  logic              fl_edge;
  logic              fl_row;
  logic              a_ready;
  logic              a_load;
  win_res_t          a_data;
  logic              shift_en;
  pair_t             new_pair;
  pair_t             cell0;
  logic [MAX_SIDE-1:0] tail;
  pair_t             cell_q   [MAX_SIDE];
  pair_t             cell_nbr [MAX_SIDE];

  col3_t             sel_col [3];
  logic [2:0]        rmask;
  logic [2:0]        cmask;
  logic [SUM_W-1:0]  sum_acc;
  logic              res_last;
  logic              res_eof;

  // Line store chain: cell 0 holds the oldest column, the tail cell sits at S-1.
  genvar gi;
  generate
    for (gi = 0; gi < MAX_SIDE; gi++) begin : g_cell
      assign tail[gi] = (last_idx_r == CNT_W'(gi));
      if (gi < MAX_SIDE - 1) begin : g_nbr
        assign cell_nbr[gi] = cell_q[gi + 1];
      end else begin : g_end
        assign cell_nbr[gi] = '0;
      end
      bmf_line_cell u_cell (
        .clk       (clk),
        .shift_en  (shift_en),
        .is_tail   (tail[gi]),
        .new_pair  (new_pair),
        .next_pair (cell_nbr[gi]),
        .pair      (cell_q[gi])
      );
    end
  endgenerate

  assign cell0 = cell_q[0];

  // Configuration clamp.
  always_comb begin
    if (cfg_wr_data < SIZE_W'(2)) begin
      size_clamp = SIZE_W'(2);
    end else if (cfg_wr_data > SIZE_W'(MAX_SIDE)) begin
      size_clamp = SIZE_W'(MAX_SIDE);
    end else begin
      size_clamp = cfg_wr_data;
    end
    size_m1 = size_clamp - SIZE_W'(1);
  end

  // Flush sequencer: next state.
  always_comb begin
    fl_state_nxt = fl_state_r;
    case (fl_state_r)
      FL_IDLE: begin
        if (accept && last_pix) begin
          fl_state_nxt = FL_EDGE;
        end
      end
      FL_EDGE: begin
        if (a_ready) begin
          fl_state_nxt = FL_ROW;
        end
      end
      FL_ROW: begin
        if (a_ready && (fl_k_r == last_idx_r)) begin
          fl_state_nxt = FL_IDLE;
        end
      end
      default: fl_state_nxt = FL_IDLE;
    endcase
  end

  // Flush sequencer: outputs.
  always_comb begin
    fl_edge = 1'b0;
    fl_row  = 1'b0;
    case (fl_state_r)
      FL_IDLE: begin
        fl_edge = 1'b0;
        fl_row  = 1'b0;
      end
      FL_EDGE: fl_edge = 1'b1;
      FL_ROW:  fl_row  = 1'b1;
      default: begin
        fl_edge = 1'b0;
        fl_row  = 1'b0;
      end
    endcase
  end

  assign fl_busy  = fl_edge || fl_row;
  assign fl_go    = fl_busy && a_ready;
  assign in_stall = fl_busy || !a_ready;
  assign accept   = in_valid && !in_stall;
  assign last_pix = (row_r == last_idx_r) && (col_r == last_idx_r);
  assign acc_emits = (col_r == '0) ? (row_r >= 2) : (row_r != '0);
  assign shift_en = accept || fl_go;
  assign a_load   = fl_go || (accept && acc_emits);

  // A new pixel pushes the middle line into the upper line; the flush recirculates.
  always_comb begin
    if (fl_busy) begin
      new_pair = cell0;
    end else begin
      new_pair = '{upper: cell0.middle, middle: in_pixel_in};
    end
  end

  // Window selection for the transaction that enters the result path this cycle.
  always_comb begin
    sel_col[0] = wold_r;
    sel_col[1] = wnew_r;
    sel_col[2] = wnew_r;
    rmask      = 3'b111;
    cmask      = 3'b111;
    res_last   = 1'b0;
    res_eof    = 1'b0;
    if (fl_edge) begin
      rmask[0] = (last_idx_r >= 2);
      cmask[2] = 1'b0;
    end else if (fl_row) begin
      sel_col[0] = '{top: fw_left_r.upper, mid: fw_left_r.middle, bot: '0};
      sel_col[1] = '{top: fw_mid_r.upper, mid: fw_mid_r.middle, bot: '0};
      sel_col[2] = '{top: cell0.upper, mid: cell0.middle, bot: '0};
      rmask[2]   = 1'b0;
      cmask[0]   = (fl_k_r != '0);
      cmask[2]   = (fl_k_r != last_idx_r);
      res_last   = (fl_k_r == last_idx_r);
      res_eof    = (fl_k_r == last_idx_r);
    end else if (col_r == '0) begin
      // Last column of the row two rows up, using the two held window columns.
      rmask[0] = (row_r >= 3);
      cmask[2] = 1'b0;
      res_last = 1'b1;
    end else begin
      sel_col[2] = '{top: cell0.upper, mid: cell0.middle, bot: in_pixel_in};
      rmask[0]   = (row_r >= 2);
      cmask[0]   = (col_r >= 2);
      res_last   = !last_pix;
    end
  end

  always_comb begin
    sum_acc = '0;
    for (int j = 0; j < 3; j++) begin
      if (cmask[j]) begin
        if (rmask[0]) sum_acc = sum_acc + SUM_W'(sel_col[j].top);
        if (rmask[1]) sum_acc = sum_acc + SUM_W'(sel_col[j].mid);
        if (rmask[2]) sum_acc = sum_acc + SUM_W'(sel_col[j].bot);
      end
    end
  end

  always_comb begin
    a_data.sum  = sum_acc;
    a_data.last = res_last;
    a_data.eof  = res_eof;
    if ((&rmask) && (&cmask)) begin
      a_data.div = DIV9;
    end else if ((&rmask) || (&cmask)) begin
      a_data.div = DIV6;
    end else begin
      a_data.div = DIV4;
    end
  end

  // Counters, window and flush window.
  always_comb begin
    last_idx_nxt = last_idx_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    fl_k_nxt     = fl_k_r;
    wnew_nxt     = wnew_r;
    wold_nxt     = wold_r;
    fw_left_nxt  = fw_left_r;
    fw_mid_nxt   = fw_mid_r;
    if (accept) begin
      wold_nxt = wnew_r;
      wnew_nxt = '{top: cell0.upper, mid: cell0.middle, bot: in_pixel_in};
      if (last_pix) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (col_r == last_idx_r) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
    if (fl_go) begin
      fw_left_nxt = fw_mid_r;
      fw_mid_nxt  = cell0;
      fl_k_nxt    = fl_edge ? '0 : fl_k_r + CNT_W'(1);
    end
    if (cfg_wr_en) begin
      last_idx_nxt = CNT_W'(size_m1);
      row_nxt      = '0;
      col_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r <= CNT_W'(RESET_SIDE - 1);
      row_r      <= '0;
      col_r      <= '0;
      fl_k_r     <= '0;
      fl_state_r <= FL_IDLE;
      wnew_r     <= '0;
      wold_r     <= '0;
    end else begin
      last_idx_r <= last_idx_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      fl_k_r     <= fl_k_nxt;
      fl_state_r <= fl_state_nxt;
      wnew_r     <= wnew_nxt;
      wold_r     <= wold_nxt;
    end
    fw_left_r <= fw_left_nxt;
    fw_mid_r  <= fw_mid_nxt;
  end

  bmf_mean_pipe u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_load    (a_load),
    .a_data    (a_data),
    .a_ready   (a_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_pixel (out_pixel_out),
    .out_last  (out_last_in_run),
    .out_eof   (out_end_of_frame)
  );

endmodule

`default_nettype wire
